[design/ticket_reader_writer_lock_top_assert.svh]
// Assertion macros shared by the lock manager's checker.
`ifndef TICKET_READER_WRITER_LOCK_TOP_ASSERT_SVH
`define TICKET_READER_WRITER_LOCK_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define TRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define TRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/trl_pkg.sv]
// Shared constants, codes and interface types of the ticket reader-writer lock manager.
package trl_pkg;

  // Sizes of the agent space, the tickets and the counters.
  localparam int NUM_AGENTS = 8;
  localparam int ID_W       = 3;
  localparam int TICKET_W   = 16;
  localparam int KIND_W     = 3;
  localparam int REQ_W      = 2;
  localparam int RCNT_W     = 4;
  localparam int PTR_W      = $clog2(NUM_AGENTS);
  localparam int FCNT_W     = $clog2(NUM_AGENTS + 1);

  localparam logic [RCNT_W-1:0] RCNT_MAX = {RCNT_W{1'b1}};

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_RD_LOCK   = 2'd0,
    REQ_RD_UNLOCK = 2'd1,
    REQ_WR_LOCK   = 2'd2,
    REQ_WR_UNLOCK = 2'd3
  } req_t;

  // Result codes.
  typedef enum logic [KIND_W-1:0] {
    RES_GRANT   = 3'd0,
    RES_WAIT    = 3'd1,
    RES_RELEASE = 3'd2,
    RES_ERROR   = 3'd3,
    RES_WAKE    = 3'd4
  } res_kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exec_more;
    logic step_more;
  } dp_status_t;

endpackage

[design/ticket_reader_writer_lock_top.sv]
// Top level of the phase-fair two-room ticket reader-writer lock manager.
//
// Usage: drive a request (in_req_type, in_requester_id, in_ticket) with start high;
// it is taken at the clock edge where start is high and busy is low. Every request
// gets an acknowledge beat first (granted, waiting, released or error), then one
// wake beat per agent it unblocks. Result beats appear on the out_ ports for one
// cycle each, marked by out_valid; out_last marks the final beat of a request.
// The first beat of a request is computed in the execute state and registered onto
// the out_ ports. busy stays high while a request executes and issues its wake beats,
// so a new request is taken only once the block is idle again. A writer unlock adds
// one wake beat per woken reader plus one for a woken writer (up to 9 beats in all);
// a reader unlock that ends a writer's drain adds one wake beat.
// The wake scan in the datapath emits one beat per cycle and busy stays high until
// the last beat is issued.
// The receiver cannot stall: beats are presented once and must be taken.
// Reset (rst_n low, synchronous) clears all tickets, room counts and waiter maps,
// opens room zero, closes room one and empties the writer queue.
module ticket_reader_writer_lock_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [trl_pkg::REQ_W-1:0]         in_req_type,
  input  logic [trl_pkg::ID_W-1:0]          in_requester_id,
  input  logic [trl_pkg::TICKET_W-1:0]      in_ticket,
  output logic                              out_valid,
  output logic [trl_pkg::KIND_W-1:0]        out_result_kind,
  output logic [trl_pkg::ID_W-1:0]          out_target_id,
  output logic [trl_pkg::TICKET_W-1:0]      out_grant_ticket,
  output logic                              out_is_writer,
  output logic                              out_last
);

  trl_pkg::ctrl_cmd_t  cmd;
  trl_pkg::dp_status_t status;

  // Sequencer.
  trl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Lock state and result generation.
  trl_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_req_type      (in_req_type),
    .in_requester_id  (in_requester_id),
    .in_ticket        (in_ticket),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_target_id    (out_target_id),
    .out_grant_ticket (out_grant_ticket),
    .out_is_writer    (out_is_writer),
    .out_last         (out_last)
  );

endmodule

[design/trl_ctrl.sv]
// Controller state machine of the lock manager: sequences load, execute and wake beats.
module trl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  trl_pkg::dp_status_t status,
  output trl_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  trl_pkg::state_t state_r;
  trl_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      trl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = trl_pkg::ST_EXEC;
        end
      end
      trl_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.exec_more ? trl_pkg::ST_SCAN : trl_pkg::ST_IDLE;
      end
      trl_pkg::ST_SCAN: begin
        cmd.step  = 1'b1;
        state_nxt = status.step_more ? trl_pkg::ST_SCAN : trl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = trl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/trl_datapath.sv]
// Datapath of the lock manager: lock state, writer queue, wake scan and result register.
module trl_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trl_pkg::ctrl_cmd_t                cmd,
  output trl_pkg::dp_status_t               status,
  input  logic [trl_pkg::REQ_W-1:0]         in_req_type,
  input  logic [trl_pkg::ID_W-1:0]          in_requester_id,
  input  logic [trl_pkg::TICKET_W-1:0]      in_ticket,
  output logic                              out_valid,
  output logic [trl_pkg::KIND_W-1:0]        out_result_kind,
  output logic [trl_pkg::ID_W-1:0]          out_target_id,
  output logic [trl_pkg::TICKET_W-1:0]      out_grant_ticket,
  output logic                              out_is_writer,
  output logic                              out_last
);

  // Latched request.
  trl_pkg::req_t                    req_type_r;
  logic [trl_pkg::ID_W-1:0]         req_id_r;
  logic [trl_pkg::TICKET_W-1:0]     req_tkt_r;

  // Lock state.
  logic [trl_pkg::TICKET_W-1:0]     nwt_r, nwt_nxt;
  logic [trl_pkg::TICKET_W-1:0]     rrt_r, rrt_nxt;
  logic [trl_pkg::TICKET_W-1:0]     turn_r, turn_nxt;
  logic [trl_pkg::RCNT_W-1:0]       cnt_r [2];
  logic [trl_pkg::RCNT_W-1:0]       cnt_nxt [2];
  logic                             open_r [2];
  logic                             open_nxt [2];
  logic [trl_pkg::NUM_AGENTS-1:0]   wmap_r [2];
  logic [trl_pkg::NUM_AGENTS-1:0]   wmap_nxt [2];
  logic [trl_pkg::TICKET_W-1:0]     wtkt_r [2];
  logic [trl_pkg::TICKET_W-1:0]     wtkt_nxt [2];
  logic [trl_pkg::ID_W-1:0]         fifo_r [trl_pkg::NUM_AGENTS];
  logic [trl_pkg::PTR_W-1:0]        head_r, head_nxt;
  logic [trl_pkg::FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic                             drain_r, drain_nxt;

  // Wake scan state.
  logic [trl_pkg::NUM_AGENTS-1:0]   mask_r, mask_nxt;
  logic [trl_pkg::TICKET_W-1:0]     stkt_r, stkt_nxt;
  logic                             pend_r, pend_nxt;

  // Result of the current beat.
  trl_pkg::res_kind_t               res_kind;
  logic [trl_pkg::ID_W-1:0]         res_id;
  logic [trl_pkg::TICKET_W-1:0]     res_tkt;
  logic                             res_wr;
  logic                             more;

  // Queue write and head read.
  logic                             fifo_we;
  logic [trl_pkg::PTR_W-1:0]        fifo_wslot;
  logic [trl_pkg::ID_W-1:0]         head_id;
  logic [trl_pkg::ID_W-1:0]         low_idx;
  logic                             rd_room;
  logic                             t_room;
  logic                             turn_room;

  // Output register.
  logic                             out_valid_r;
  trl_pkg::res_kind_t               out_kind_r;
  logic [trl_pkg::ID_W-1:0]         out_id_r;
  logic [trl_pkg::TICKET_W-1:0]     out_tkt_r;
  logic                             out_wr_r;
  logic                             out_last_r;

  // Counts the agents marked in a waiter map.
  function automatic logic [trl_pkg::RCNT_W-1:0] popcnt(
    input logic [trl_pkg::NUM_AGENTS-1:0] m
  );
    logic [trl_pkg::RCNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < trl_pkg::NUM_AGENTS; i++) begin
      c = c + trl_pkg::RCNT_W'(m[i]);
    end
    return c;
  endfunction

  assign head_id    = fifo_r[head_r];
  assign fifo_wslot = head_r + fcnt_r[trl_pkg::PTR_W-1:0];
  assign rd_room    = rrt_r[0];
  assign t_room     = req_tkt_r[0];
  assign turn_room  = turn_r[0];

  // Lowest agent still to be woken.
  always_comb begin
    low_idx = '0;
    for (int i = trl_pkg::NUM_AGENTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = trl_pkg::ID_W'(i);
      end
    end
  end

  // Request decode and state update.
  always_comb begin
    nwt_nxt   = nwt_r;
    rrt_nxt   = rrt_r;
    turn_nxt  = turn_r;
    cnt_nxt   = cnt_r;
    open_nxt  = open_r;
    wmap_nxt  = wmap_r;
    wtkt_nxt  = wtkt_r;
    head_nxt  = head_r;
    fcnt_nxt  = fcnt_r;
    drain_nxt = drain_r;
    mask_nxt  = mask_r;
    stkt_nxt  = stkt_r;
    pend_nxt  = pend_r;
    fifo_we   = 1'b0;
    res_kind  = trl_pkg::RES_ERROR;
    res_id    = req_id_r;
    res_tkt   = '0;
    res_wr    = 1'b0;
    more      = 1'b0;
    if (cmd.exec) begin
      unique case (req_type_r)
        trl_pkg::REQ_RD_LOCK: begin
          if (cnt_r[rd_room] == trl_pkg::RCNT_MAX || wmap_r[rd_room][req_id_r]) begin
            res_kind = trl_pkg::RES_ERROR;
          end else begin
            cnt_nxt[rd_room] = cnt_r[rd_room] + 1'b1;
            res_tkt          = rrt_r;
            if (open_r[rd_room]) begin
              res_kind = trl_pkg::RES_GRANT;
            end else begin
              wmap_nxt[rd_room][req_id_r] = 1'b1;
              wtkt_nxt[rd_room]           = rrt_r;
              res_kind                    = trl_pkg::RES_WAIT;
            end
          end
        end
        trl_pkg::REQ_RD_UNLOCK: begin
          res_tkt = req_tkt_r;
          if (cnt_r[t_room] <= popcnt(wmap_r[t_room])) begin
            res_kind = trl_pkg::RES_ERROR;
          end else begin
            cnt_nxt[t_room] = cnt_r[t_room] - 1'b1;
            res_kind        = trl_pkg::RES_RELEASE;
            // The last reader leaving the draining room hands the lock to the head writer.
            if (drain_r && fcnt_r != '0 && t_room == turn_room &&
                cnt_r[t_room] == trl_pkg::RCNT_W'(1)) begin
              open_nxt[t_room] = 1'b0;
              drain_nxt        = 1'b0;
              pend_nxt         = 1'b1;
              more             = 1'b1;
            end
          end
        end
        trl_pkg::REQ_WR_LOCK: begin
          res_wr = 1'b1;
          if (fcnt_r == trl_pkg::FCNT_W'(trl_pkg::NUM_AGENTS)) begin
            res_kind = trl_pkg::RES_ERROR;
          end else begin
            fifo_we  = 1'b1;
            fcnt_nxt = fcnt_r + 1'b1;
            nwt_nxt  = nwt_r + 1'b1;
            if (fcnt_r == '0) begin
              // This writer is the new head: it moves readers to the other room.
              rrt_nxt = rrt_r + 1'b1;
              res_tkt = turn_r;
              if (cnt_r[turn_room] == '0) begin
                open_nxt[turn_room] = 1'b0;
                drain_nxt           = 1'b0;
                res_kind            = trl_pkg::RES_GRANT;
              end else begin
                drain_nxt = 1'b1;
                res_kind  = trl_pkg::RES_WAIT;
              end
            end else begin
              res_tkt  = nwt_r;
              res_kind = trl_pkg::RES_WAIT;
            end
          end
        end
        trl_pkg::REQ_WR_UNLOCK: begin
          res_wr  = 1'b1;
          res_tkt = req_tkt_r;
          if (fcnt_r == '0 || drain_r || req_tkt_r != turn_r || head_id != req_id_r ||
              cnt_r[t_room] != '0) begin
            res_kind = trl_pkg::RES_ERROR;
          end else begin
            res_kind          = trl_pkg::RES_RELEASE;
            // Open the other room and queue its waiters for wake beats.
            open_nxt[~t_room] = 1'b1;
            mask_nxt          = wmap_r[~t_room];
            stkt_nxt          = wtkt_r[~t_room];
            wmap_nxt[~t_room] = '0;
            turn_nxt          = turn_r + 1'b1;
            head_nxt          = head_r + 1'b1;
            fcnt_nxt          = fcnt_r - 1'b1;
            // The next queued writer starts its turn on the room just opened.
            if (fcnt_r != trl_pkg::FCNT_W'(1)) begin
              rrt_nxt = rrt_r + 1'b1;
              if (cnt_r[~t_room] == '0) begin
                open_nxt[~t_room] = 1'b0;
                drain_nxt         = 1'b0;
                pend_nxt          = 1'b1;
              end else begin
                drain_nxt = 1'b1;
              end
            end
            more = (wmap_r[~t_room] != '0) ||
                   (fcnt_r != trl_pkg::FCNT_W'(1) && cnt_r[~t_room] == '0);
          end
        end
        default: begin
          res_kind = trl_pkg::RES_ERROR;
        end
      endcase
    end else if (cmd.step) begin
      res_kind = trl_pkg::RES_WAKE;
      if (mask_r != '0) begin
        // One reader wake per beat, lowest agent first.
        res_id   = low_idx;
        res_tkt  = stkt_r;
        res_wr   = 1'b0;
        mask_nxt = mask_r & (mask_r - 1'b1);
        more     = ((mask_r & (mask_r - 1'b1)) != '0) || pend_r;
      end else begin
        // Wake for the writer that now holds the lock.
        res_id   = head_id;
        res_tkt  = turn_r;
        res_wr   = 1'b1;
        pend_nxt = 1'b0;
      end
    end
  end

  assign status.exec_more = more;
  assign status.step_more = more;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= trl_pkg::req_t'(in_req_type);
      req_id_r   <= in_requester_id;
      req_tkt_r  <= in_ticket;
    end
  end

  // Writer queue storage.
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_r[fifo_wslot] <= req_id_r;
    end
  end

  // Lock state and scan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nwt_r   <= '0;
      rrt_r   <= '0;
      turn_r  <= '0;
      cnt_r   <= '{default: '0};
      open_r  <= '{1'b1, 1'b0};
      wmap_r  <= '{default: '0};
      wtkt_r  <= '{default: '0};
      head_r  <= '0;
      fcnt_r  <= '0;
      drain_r <= 1'b0;
      mask_r  <= '0;
      stkt_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      nwt_r   <= nwt_nxt;
      rrt_r   <= rrt_nxt;
      turn_r  <= turn_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
      wmap_r  <= wmap_nxt;
      wtkt_r  <= wtkt_nxt;
      head_r  <= head_nxt;
      fcnt_r  <= fcnt_nxt;
      drain_r <= drain_nxt;
      mask_r  <= mask_nxt;
      stkt_r  <= stkt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Result register: one beat per execute or wake step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec | cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec | cmd.step) begin
      out_kind_r <= res_kind;
      out_id_r   <= res_id;
      out_tkt_r  <= res_tkt;
      out_wr_r   <= res_wr;
      out_last_r <= !more;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_target_id    = out_id_r;
  assign out_grant_ticket = out_tkt_r;
  assign out_is_writer    = out_wr_r;
  assign out_last         = out_last_r;

endmodule

[design/trl_checker.sv]
// Port-level checker of the lock manager and its bind to the top level.
`include "ticket_reader_writer_lock_top_assert.svh"

module trl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [trl_pkg::KIND_W-1:0]   out_result_kind,
  input logic                         out_last
);

  // A taken request keeps the block busy in the next cycle.
  `TRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but block not busy")

  // Beats of one request come back to back until the last one.
  `TRL_ASSERT_NEXT(a_burst_cont, out_valid && !out_last, out_valid, "result burst broke off")

  // A wake beat never opens a burst.
  `TRL_ASSERT_NOW(a_wake_follows, out_valid && out_result_kind == trl_pkg::RES_WAKE,
                  $past(out_valid) && !$past(out_last), "wake beat without acknowledge")

  // Going idle coincides with the last beat of the request.
  `TRL_ASSERT_NOW(a_idle_last, $fell(busy) && $past(rst_n), out_valid && out_last,
                  "idle without final beat")

endmodule

bind ticket_reader_writer_lock_top trl_checker u_trl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_last        (out_last)
);
